[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication on the rising clock edge, skipped during reset.
`define FPSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check an implication whose consequence holds in the next cycle.
`define FPSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/fpsa_pkg.sv]
package fpsa_pkg;

    localparam int CMD_W    = 2;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_BULK   = 2'd2,
        CMD_CONTIG = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_EMPTY  = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_NORUN  = 3'd3,
        STAT_BADCNT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SEL_ZERO  = 2'd0,
        SEL_RDATA = 2'd1,
        SEL_START = 2'd2
    } frame_sel_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'd0,
        S_CHECK  = 4'd1,
        S_BREAD  = 4'd2,
        S_BEMIT  = 4'd3,
        S_SREAD  = 4'd4,
        S_SEVAL  = 4'd5,
        S_MREAD  = 4'd6,
        S_MWRITE = 4'd7,
        S_SHRINK = 4'd8,
        S_RESULT = 4'd9
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch_in;
        logic       push;
        logic       pop;
        logic       bulk_init;
        logic       rd_idx;
        logic       bulk_step;
        logic       scan_init;
        logic       scan_eval;
        logic       scan_next;
        logic       move_init;
        logic       rd_src;
        logic       move_step;
        logic       shrink;
        logic       set_res;
        status_t    res_code;
        frame_sel_t res_sel;
        logic       out_load;
        status_t    out_status;
        frame_sel_t out_sel;
        logic       out_last;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t       cmd;
        status_t    err;
        logic       out_free;
        logic       rem_one;
        logic       scan_found;
        logic       scan_bottom;
        logic       move_none;
        logic       move_end;
        status_t    res_code;
        frame_sel_t res_sel;
    } dp_stat_t;

endpackage

[src/fpsa_ram.sv]
module fpsa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/fpsa_ctrl.sv]
module fpsa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fpsa_pkg::dp_stat_t stat,
    output fpsa_pkg::ctrl_t    ctrl
);

    fpsa_pkg::state_t state_reg;
    fpsa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpsa_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fpsa_pkg::S_IDLE: begin
                if (in_valid) begin
                    state_next = fpsa_pkg::S_CHECK;
                end
            end
            fpsa_pkg::S_CHECK: begin
                if (stat.err != fpsa_pkg::STAT_OK) begin
                    state_next = fpsa_pkg::S_RESULT;
                end else begin
                    case (stat.cmd)
                        fpsa_pkg::CMD_BULK:   state_next = fpsa_pkg::S_BREAD;
                        fpsa_pkg::CMD_CONTIG: state_next = fpsa_pkg::S_SREAD;
                        default:              state_next = fpsa_pkg::S_RESULT;
                    endcase
                end
            end
            fpsa_pkg::S_BREAD: state_next = fpsa_pkg::S_BEMIT;
            fpsa_pkg::S_BEMIT: begin
                if (stat.out_free) begin
                    state_next = stat.rem_one ? fpsa_pkg::S_IDLE : fpsa_pkg::S_BREAD;
                end
            end
            fpsa_pkg::S_SREAD: state_next = fpsa_pkg::S_SEVAL;
            fpsa_pkg::S_SEVAL: begin
                if (stat.scan_found) begin
                    state_next = stat.move_none ? fpsa_pkg::S_SHRINK : fpsa_pkg::S_MREAD;
                end else if (stat.scan_bottom) begin
                    state_next = fpsa_pkg::S_RESULT;
                end else begin
                    state_next = fpsa_pkg::S_SREAD;
                end
            end
            fpsa_pkg::S_MREAD: state_next = fpsa_pkg::S_MWRITE;
            fpsa_pkg::S_MWRITE: begin
                state_next = stat.move_end ? fpsa_pkg::S_SHRINK : fpsa_pkg::S_MREAD;
            end
            fpsa_pkg::S_SHRINK: state_next = fpsa_pkg::S_RESULT;
            fpsa_pkg::S_RESULT: begin
                if (stat.out_free) begin
                    state_next = fpsa_pkg::S_IDLE;
                end
            end
            default: state_next = fpsa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            fpsa_pkg::S_IDLE: begin
                in_ready      = 1'b1;
                ctrl.latch_in = in_valid;
            end
            fpsa_pkg::S_CHECK: begin
                if (stat.err != fpsa_pkg::STAT_OK) begin
                    ctrl.set_res  = 1'b1;
                    ctrl.res_code = stat.err;
                    ctrl.res_sel  = fpsa_pkg::SEL_ZERO;
                end else begin
                    case (stat.cmd)
                        fpsa_pkg::CMD_ALLOC: begin
                            ctrl.pop      = 1'b1;
                            ctrl.set_res  = 1'b1;
                            ctrl.res_code = fpsa_pkg::STAT_OK;
                            ctrl.res_sel  = fpsa_pkg::SEL_RDATA;
                        end
                        fpsa_pkg::CMD_FREE: begin
                            ctrl.push     = 1'b1;
                            ctrl.set_res  = 1'b1;
                            ctrl.res_code = fpsa_pkg::STAT_OK;
                            ctrl.res_sel  = fpsa_pkg::SEL_ZERO;
                        end
                        fpsa_pkg::CMD_BULK:   ctrl.bulk_init = 1'b1;
                        default:              ctrl.scan_init = 1'b1;
                    endcase
                end
            end
            fpsa_pkg::S_BREAD: ctrl.rd_idx = 1'b1;
            fpsa_pkg::S_BEMIT: begin
                if (stat.out_free) begin
                    ctrl.out_load   = 1'b1;
                    ctrl.out_status = fpsa_pkg::STAT_OK;
                    ctrl.out_sel    = fpsa_pkg::SEL_RDATA;
                    ctrl.out_last   = stat.rem_one;
                    ctrl.bulk_step  = 1'b1;
                end
            end
            fpsa_pkg::S_SREAD: ctrl.rd_idx = 1'b1;
            fpsa_pkg::S_SEVAL: begin
                ctrl.scan_eval = 1'b1;
                if (stat.scan_found) begin
                    ctrl.move_init = 1'b1;
                    ctrl.set_res   = 1'b1;
                    ctrl.res_code  = fpsa_pkg::STAT_OK;
                    ctrl.res_sel   = fpsa_pkg::SEL_START;
                end else if (stat.scan_bottom) begin
                    ctrl.set_res  = 1'b1;
                    ctrl.res_code = fpsa_pkg::STAT_NORUN;
                    ctrl.res_sel  = fpsa_pkg::SEL_ZERO;
                end else begin
                    ctrl.scan_next = 1'b1;
                end
            end
            fpsa_pkg::S_MREAD:  ctrl.rd_src    = 1'b1;
            fpsa_pkg::S_MWRITE: ctrl.move_step = 1'b1;
            fpsa_pkg::S_SHRINK: ctrl.shrink    = 1'b1;
            fpsa_pkg::S_RESULT: begin
                if (stat.out_free) begin
                    ctrl.out_load   = 1'b1;
                    ctrl.out_status = stat.res_code;
                    ctrl.out_sel    = stat.res_sel;
                    ctrl.out_last   = 1'b1;
                end
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

[src/fpsa_dp.sv]
module fpsa_dp #(
    parameter int DEPTH      = 4096,
    parameter int MAX_BURST  = 64,
    parameter int FRAME_BITS = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fpsa_pkg::ctrl_t                ctrl,
    output fpsa_pkg::dp_stat_t             stat,
    input  fpsa_pkg::cmd_t                 in_cmd,
    input  logic [FRAME_BITS-1:0]          in_frame,
    input  logic [fpsa_pkg::COUNT_W-1:0]   in_count,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [FRAME_BITS-1:0]          out_frame,
    output logic [fpsa_pkg::STATUS_W-1:0]  out_status,
    output logic                           out_last
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CW     = (CNT_W > fpsa_pkg::COUNT_W) ? CNT_W : fpsa_pkg::COUNT_W;
    localparam int NW     = fpsa_pkg::COUNT_W;

    logic [CNT_W-1:0]      cnt_reg,       cnt_next;
    fpsa_pkg::cmd_t        cmd_reg,       cmd_next;
    logic [FRAME_BITS-1:0] frame_in_reg,  frame_in_next;
    logic [NW-1:0]         n_reg,         n_next;
    logic [ADDR_W-1:0]     idx_reg,       idx_next;
    logic [NW-1:0]         rem_reg,       rem_next;
    logic [NW-1:0]         len_reg,       len_next;
    logic [ADDR_W-1:0]     hi_reg,        hi_next;
    logic [FRAME_BITS-1:0] start_reg,     start_next;
    logic [FRAME_BITS-1:0] prev_reg,      prev_next;
    logic                  first_reg,     first_next;
    logic [CNT_W-1:0]      src_reg,       src_next;
    fpsa_pkg::status_t     res_code_reg,  res_code_next;
    fpsa_pkg::frame_sel_t  res_sel_reg,   res_sel_next;
    logic                  out_valid_reg, out_valid_next;
    fpsa_pkg::status_t     out_status_reg, out_status_next;
    logic [FRAME_BITS-1:0] out_frame_reg, out_frame_next;
    logic                  out_last_reg,  out_last_next;

    logic [CW-1:0]         n_ext;
    logic [CW-1:0]         cnt_ext;
    logic [CNT_W-1:0]      n_cnt;
    logic [CNT_W-1:0]      cnt_dec;
    logic [CNT_W-1:0]      cnt_sub;
    logic [CNT_W-1:0]      dst;
    logic [CNT_W-1:0]      hi_plus;
    fpsa_pkg::status_t     err;
    logic                  chain;
    logic [NW-1:0]         new_len;
    logic [ADDR_W-1:0]     new_hi;
    logic [FRAME_BITS-1:0] new_start;

    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [FRAME_BITS-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [FRAME_BITS-1:0] ram_rd_data;

    fpsa_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign n_ext   = CW'(n_reg);
    assign cnt_ext = CW'(cnt_reg);
    assign n_cnt   = n_ext[CNT_W-1:0];
    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign cnt_sub = cnt_reg - n_cnt;
    assign dst     = src_reg - n_cnt;

    always_comb begin
        case (cmd_reg)
            fpsa_pkg::CMD_ALLOC: begin
                err = (cnt_reg == '0) ? fpsa_pkg::STAT_EMPTY : fpsa_pkg::STAT_OK;
            end
            fpsa_pkg::CMD_FREE: begin
                err = (cnt_reg == CNT_W'(DEPTH)) ? fpsa_pkg::STAT_FULL : fpsa_pkg::STAT_OK;
            end
            default: begin
                if (n_reg == '0 || n_reg > NW'(MAX_BURST)) begin
                    err = fpsa_pkg::STAT_BADCNT;
                end else if (n_ext > cnt_ext) begin
                    err = fpsa_pkg::STAT_EMPTY;
                end else begin
                    err = fpsa_pkg::STAT_OK;
                end
            end
        endcase
    end

    // Run tracking: the entry just read extends the run when it is one above the one before.
    assign chain     = !first_reg &&
                       ({1'b0, ram_rd_data} == ({1'b0, prev_reg} + (FRAME_BITS + 1)'(1)));
    assign new_len   = chain ? (len_reg + NW'(1)) : NW'(1);
    assign new_hi    = chain ? hi_reg : idx_reg;
    assign new_start = chain ? start_reg : ram_rd_data;
    assign hi_plus   = CNT_W'(new_hi) + CNT_W'(1);

    assign ram_rd_en   = ctrl.pop | ctrl.rd_idx | ctrl.rd_src;
    assign ram_rd_addr = ctrl.pop ? cnt_dec[ADDR_W-1:0] :
                         (ctrl.rd_src ? src_reg[ADDR_W-1:0] : idx_reg);
    assign ram_wr_en   = ctrl.push | ctrl.move_step;
    assign ram_wr_addr = ctrl.push ? cnt_reg[ADDR_W-1:0] : dst[ADDR_W-1:0];
    assign ram_wr_data = ctrl.push ? frame_in_reg : ram_rd_data;

    always_comb begin
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        frame_in_next   = frame_in_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        len_next        = len_reg;
        hi_next         = hi_reg;
        start_next      = start_reg;
        prev_next       = prev_reg;
        first_next      = first_reg;
        src_next        = src_reg;
        res_code_next   = res_code_reg;
        res_sel_next    = res_sel_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_frame_next  = out_frame_reg;
        out_last_next   = out_last_reg;

        if (ctrl.latch_in) begin
            cmd_next      = in_cmd;
            frame_in_next = in_frame;
            n_next        = in_count;
        end
        if (ctrl.push) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (ctrl.pop) begin
            cnt_next = cnt_dec;
        end
        if (ctrl.bulk_init) begin
            cnt_next = cnt_sub;
            idx_next = cnt_sub[ADDR_W-1:0];
            rem_next = n_reg;
        end
        if (ctrl.bulk_step) begin
            idx_next = idx_reg + ADDR_W'(1);
            rem_next = rem_reg - NW'(1);
        end
        if (ctrl.scan_init) begin
            idx_next   = cnt_dec[ADDR_W-1:0];
            first_next = 1'b1;
        end
        if (ctrl.scan_eval) begin
            len_next   = new_len;
            hi_next    = new_hi;
            start_next = new_start;
            prev_next  = ram_rd_data;
            first_next = 1'b0;
        end
        if (ctrl.scan_next) begin
            idx_next = idx_reg - ADDR_W'(1);
        end
        if (ctrl.move_init) begin
            src_next = hi_plus;
        end
        if (ctrl.move_step) begin
            src_next = src_reg + CNT_W'(1);
        end
        if (ctrl.shrink) begin
            cnt_next = cnt_sub;
        end
        if (ctrl.set_res) begin
            res_code_next = ctrl.res_code;
            res_sel_next  = ctrl.res_sel;
        end

        if (ctrl.out_load) begin
            out_valid_next  = 1'b1;
            out_status_next = ctrl.out_status;
            out_last_next   = ctrl.out_last;
            case (ctrl.out_sel)
                fpsa_pkg::SEL_RDATA: out_frame_next = ram_rd_data;
                fpsa_pkg::SEL_START: out_frame_next = start_reg;
                default:             out_frame_next = '0;
            endcase
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        frame_in_reg   <= frame_in_next;
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        rem_reg        <= rem_next;
        len_reg        <= len_next;
        hi_reg         <= hi_next;
        start_reg      <= start_next;
        prev_reg       <= prev_next;
        first_reg      <= first_next;
        src_reg        <= src_next;
        res_code_reg   <= res_code_next;
        res_sel_reg    <= res_sel_next;
        out_status_reg <= out_status_next;
        out_frame_reg  <= out_frame_next;
        out_last_reg   <= out_last_next;
    end

    always_comb begin
        stat             = '0;
        stat.cmd         = cmd_reg;
        stat.err         = err;
        stat.out_free    = !out_valid_reg || out_ready;
        stat.rem_one     = (rem_reg == NW'(1));
        stat.scan_found  = (new_len >= n_reg);
        stat.scan_bottom = (idx_reg == '0);
        stat.move_none   = (hi_plus == cnt_reg);
        stat.move_end    = ((src_reg + CNT_W'(1)) == cnt_reg);
        stat.res_code    = res_code_reg;
        stat.res_sel     = res_sel_reg;
    end

    assign out_valid  = out_valid_reg;
    assign out_frame  = out_frame_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

[src/free_page_stack_allocator.sv]
// Single alloc or free: the result goes to the output register, then the block is idle again.
// Bulk alloc of n pages: each frame needs a stack memory read and a result slot.
// Contiguous alloc: scan entries down from the top, then move those above the run down; a miss ends at the bottom.
// The stack memory has a registered read, so scan and move each read an entry in one state and use it in the next.
// Reset (aresetn low, synchronous) empties the stack and drops any pending result;
// the stack memory itself is not cleared.
module free_page_stack_allocator #(
    parameter int DEPTH      = 4096,
    parameter int MAX_BURST  = 64,
    parameter int FRAME_BITS = 20,
    localparam int S_TDATA_W = ((FRAME_BITS + fpsa_pkg::COUNT_W + 7) / 8) * 8,
    localparam int M_TDATA_W = ((FRAME_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, from bit 0 up: frame_in [FRAME_BITS], count [7], zero pad
    input  logic [S_TDATA_W-1:0]          s_tdata,
    // s_tuser: cmd [2]
    input  logic [fpsa_pkg::CMD_W-1:0]    s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, from bit 0 up: frame_out [FRAME_BITS], zero pad
    output logic [M_TDATA_W-1:0]          m_tdata,
    // m_tuser: status [3]
    output logic [fpsa_pkg::STATUS_W-1:0] m_tuser,
    output logic                          m_tlast
);

    fpsa_pkg::ctrl_t       ctrl;
    fpsa_pkg::dp_stat_t    stat;
    logic [FRAME_BITS-1:0] out_frame;

    // Controller: accepts one transfer in idle, then sequences the stack work.
    fpsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // Datapath: stack memory, count, scan tracker and the output register.
    // The output register lets a new transfer be taken while a result still waits.
    fpsa_dp #(
        .DEPTH      (DEPTH),
        .MAX_BURST  (MAX_BURST),
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .stat       (stat),
        .in_cmd     (fpsa_pkg::cmd_t'(s_tuser)),
        .in_frame   (s_tdata[FRAME_BITS-1:0]),
        .in_count   (s_tdata[FRAME_BITS +: fpsa_pkg::COUNT_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_frame  (out_frame),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    // Zero-extend the frame to whole bytes.
    assign m_tdata = M_TDATA_W'(out_frame);

endmodule

[src/fpsa_checker.sv]
`include "assert_macros.svh"

module fpsa_checker #(
    parameter int M_W = 24
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [M_W-1:0]                m_tdata,
    input logic [fpsa_pkg::STATUS_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // A stalled result holds until transferred.
    `FPSA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Errors give a single result carrying frame zero.
    `FPSA_ASSERT_IMPLY(a_err_single, aclk, aresetn, m_tvalid && (m_tuser != fpsa_pkg::STAT_OK), m_tlast && (m_tdata == '0))

    // Only bulk results can be non-final, and those are always good.
    `FPSA_ASSERT_IMPLY(a_mid_ok, aclk, aresetn, m_tvalid && !m_tlast, m_tuser == fpsa_pkg::STAT_OK)

    // One item at a time: no transfer is taken in the cycle after one was.
    `FPSA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind free_page_stack_allocator fpsa_checker #(.M_W(M_TDATA_W)) u_fpsa_checker (.*);

[sim/page_stack_checker.sv]
`timescale 1ns / 100ps

module page_stack_checker #(
    parameter int DEPTH      = 4096,
    parameter int MAX_BURST  = 64,
    parameter int FRAME_BITS = 20,
    parameter int S_TDATA_W  = 32,
    parameter int M_TDATA_W  = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // s_tdata, from bit 0 up: frame_in [FRAME_BITS], count [7], zero pad
    input  logic [S_TDATA_W-1:0]          s_tdata,
    // s_tuser: cmd [2]
    input  logic [fpsa_pkg::CMD_W-1:0]    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, from bit 0 up: frame_out [FRAME_BITS], zero pad
    input  logic [M_TDATA_W-1:0]          m_tdata,
    // m_tuser: status [3]
    input  logic [fpsa_pkg::STATUS_W-1:0] m_tuser,
    input  logic                          m_tlast,
    output int                            mismatch_count,
    output int                            results_owed,
    output int                            pages_held,
    output int                            results_seen
);

    typedef struct {
        fpsa_pkg::status_t     status;
        logic [FRAME_BITS-1:0] frame;
        logic                  last;
    } page_result_t;

    page_result_t          owed_q[$];
    logic [FRAME_BITS-1:0] page_stack [DEPTH];
    int                    page_top = 0;
    int                    errors   = 0;
    int                    seen     = 0;

    task automatic owe(fpsa_pkg::status_t st, logic [FRAME_BITS-1:0] fr, logic lst);
        page_result_t r;
        r.status = st;
        r.frame  = fr;
        r.last   = lst;
        owed_q.push_back(r);
    endtask

    // Walk down from the top for the first run whose frames rise by one going down,
    // take its top n entries and slide everything above them down.
    task automatic take_run(int n);
        int                    top;
        int                    hi;
        int                    lo;
        logic [FRAME_BITS-1:0] start;
        top = page_top;
        while (top > 0) begin
            hi = top - 1;
            lo = hi;
            while (lo > 0 && {1'b0, page_stack[lo]} + 1'b1 == {1'b0, page_stack[lo-1]})
                lo--;
            if (hi - lo + 1 >= n) begin
                start = page_stack[hi];
                for (int j = top; j < page_top; j++)
                    page_stack[j-n] = page_stack[j];
                page_top -= n;
                owe(fpsa_pkg::STAT_OK, start, 1'b1);
                return;
            end
            top = lo;
        end
        owe(fpsa_pkg::STAT_NORUN, '0, 1'b1);
    endtask

    task automatic predict_request(fpsa_pkg::cmd_t cmd, logic [FRAME_BITS-1:0] frame, int n);
        int base;
        case (cmd)
            fpsa_pkg::CMD_ALLOC: begin
                if (page_top == 0) begin
                    owe(fpsa_pkg::STAT_EMPTY, '0, 1'b1);
                end else begin
                    page_top--;
                    owe(fpsa_pkg::STAT_OK, page_stack[page_top], 1'b1);
                end
            end
            fpsa_pkg::CMD_FREE: begin
                if (page_top >= DEPTH) begin
                    owe(fpsa_pkg::STAT_FULL, '0, 1'b1);
                end else begin
                    page_stack[page_top] = frame;
                    page_top++;
                    owe(fpsa_pkg::STAT_OK, '0, 1'b1);
                end
            end
            default: begin
                if (n == 0 || n > MAX_BURST) begin
                    owe(fpsa_pkg::STAT_BADCNT, '0, 1'b1);
                end else if (n > page_top) begin
                    owe(fpsa_pkg::STAT_EMPTY, '0, 1'b1);
                end else if (cmd == fpsa_pkg::CMD_CONTIG) begin
                    take_run(n);
                end else begin
                    // lowest taken slot first, old top last
                    base = page_top - n;
                    for (int i = 0; i < n; i++)
                        owe(fpsa_pkg::STAT_OK, page_stack[base+i], i == n - 1);
                    page_top = base;
                end
            end
        endcase
    endtask

    task automatic note_error();
        errors++;
    endtask

    task automatic check_result(logic [fpsa_pkg::STATUS_W-1:0] st,
                                logic [FRAME_BITS-1:0] fr, logic lst);
        page_result_t want;
        seen++;
        if (owed_q.size() == 0) begin
            $error("result with no request waiting: status %0d frame %h last %b",
                   st, fr, lst);
            note_error();
            return;
        end
        want = owed_q.pop_front();
        if (st !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, st);
            note_error();
        end
        if (fr !== want.frame) begin
            $error("frame_out: expected %h, actual %h", want.frame, fr);
            note_error();
        end
        if (lst !== want.last) begin
            $error("last: expected %b, actual %b", want.last, lst);
            note_error();
        end
    endtask

    // Results first: one accepted at the same edge as a request belongs to an older one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            owed_q.delete();
            page_top = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tuser, m_tdata[FRAME_BITS-1:0], m_tlast);
            if (s_tvalid && s_tready)
                predict_request(fpsa_pkg::cmd_t'(s_tuser), s_tdata[FRAME_BITS-1:0],
                                int'(s_tdata[FRAME_BITS +: fpsa_pkg::COUNT_W]));
        end
        mismatch_count <= errors;
        results_owed   <= owed_q.size();
        pages_held     <= page_top;
        results_seen   <= seen;
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH          = 4096;
    localparam int MAX_BURST      = 64;
    localparam int FRAME_BITS     = 20;
    localparam int S_TDATA_W      = ((FRAME_BITS + fpsa_pkg::COUNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((FRAME_BITS + 7) / 8) * 8;
    localparam int FRAME_MAX      = (1 << FRAME_BITS) - 1;
    localparam int COUNT_MAX      = (1 << fpsa_pkg::COUNT_W) - 1;
    // long receiver hold-off; the block backs up and stops taking requests
    localparam int RX_HOLD_CYCLES = 400;
    // level above which random traffic turns to draining
    localparam int LEVEL_CAP      = 128;
    localparam int TAIL_CYCLES    = 200;
    localparam int CYCLE_LIMIT    = 5_000_000;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]            s_tdata  = '0;
    logic [fpsa_pkg::CMD_W-1:0]      s_tuser  = '0;
    logic                            m_tready = 1'b0;
    wire                             s_tready;
    wire                             m_tvalid;
    wire [M_TDATA_W-1:0]             m_tdata;
    wire [fpsa_pkg::STATUS_W-1:0]    m_tuser;
    wire                             m_tlast;

    int mismatches;
    int owed;
    int pages;
    int results;

    int cycles       = 0;
    int requests     = 0;
    int hold_tickets = 0;
    bit quiet        = 1'b0;
    bit valid_up     = 1'b0;

    always #1 aclk = ~aclk;

    always @(posedge aclk) cycles <= cycles + 1;

    free_page_stack_allocator #(
        .DEPTH      (DEPTH),
        .MAX_BURST  (MAX_BURST),
        .FRAME_BITS (FRAME_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    page_stack_checker #(
        .DEPTH      (DEPTH),
        .MAX_BURST  (MAX_BURST),
        .FRAME_BITS (FRAME_BITS),
        .S_TDATA_W  (S_TDATA_W),
        .M_TDATA_W  (M_TDATA_W)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatches),
        .results_owed   (owed),
        .pages_held     (pages),
        .results_seen   (results)
    );

    // Abort a hung run.
    initial begin : watchdog
        wait (cycles >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Result side: ready stretches, short random stalls, and one long hold-off on request.
    // Each pass makes a single assignment and then lets at least one edge go by.
    initial begin : receiver
        int holds_served;
        holds_served = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_tickets != holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Offer one request and hold it until the transfer. Valid stays high into the
    // next request unless a random gap drops it here.
    task automatic issue(fpsa_pkg::cmd_t cmd, int frame, int count);
        s_tvalid <= 1'b1;
        valid_up = 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({fpsa_pkg::COUNT_W'(count), FRAME_BITS'(frame)});
        do @(posedge aclk); while (!s_tready);
        requests++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            valid_up = 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every expected result has arrived.
    task automatic settle();
        if (valid_up) begin
            s_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
        do @(posedge aclk); while (owed != 0);
    endtask

    // Free a run of frames top-down, so the run reads base..base+len-1 from the top.
    task automatic push_run(int base, int len);
        for (int i = len - 1; i >= 0; i--)
            issue(fpsa_pkg::CMD_FREE, base + i, $urandom_range(0, COUNT_MAX));
    endtask

    task automatic directed_checks();
        // errors on an empty stack
        issue(fpsa_pkg::CMD_ALLOC, FRAME_MAX, COUNT_MAX);
        issue(fpsa_pkg::CMD_BULK, $urandom, 1);
        issue(fpsa_pkg::CMD_CONTIG, $urandom, 0);
        issue(fpsa_pkg::CMD_BULK, $urandom, MAX_BURST + 1);
        issue(fpsa_pkg::CMD_CONTIG, $urandom, COUNT_MAX);
        issue(fpsa_pkg::CMD_CONTIG, $urandom, MAX_BURST);
        // largest frame over frame 0 must not chain
        issue(fpsa_pkg::CMD_FREE, 0, COUNT_MAX);
        issue(fpsa_pkg::CMD_FREE, FRAME_MAX, 0);
        issue(fpsa_pkg::CMD_CONTIG, 0, 2);
        issue(fpsa_pkg::CMD_ALLOC, 0, 0);
        issue(fpsa_pkg::CMD_ALLOC, FRAME_MAX, 0);
        // a lone bottom entry starts a run
        issue(fpsa_pkg::CMD_FREE, 'h10, 0);
        issue(fpsa_pkg::CMD_CONTIG, $urandom, 1);
        // run ending at the bottom with an unrelated frame above it, moved down after
        push_run('h30, 3);
        issue(fpsa_pkg::CMD_FREE, 'h7, 0);
        issue(fpsa_pkg::CMD_CONTIG, $urandom, 3);
        // bulk order: lowest slot first, old top last
        issue(fpsa_pkg::CMD_FREE, 'hABCDE, 0);
        issue(fpsa_pkg::CMD_FREE, 'h12345, 0);
        issue(fpsa_pkg::CMD_BULK, $urandom, 3);
        issue(fpsa_pkg::CMD_ALLOC, $urandom, 0);
    endtask

    // Mostly well-formed traffic: runs pushed and then taken by contiguous and bulk
    // allocs, mixed with single allocs, stray frees and raw noise.
    task automatic random_traffic(int n_items);
        int first;
        int lvl;
        int pick;
        int len;
        int base;
        int cnt;
        first = requests;
        while (requests - first < n_items) begin
            lvl  = pages;
            pick = $urandom_range(0, 99);
            if (lvl > LEVEL_CAP)
                pick = 65;
            else if (lvl < 16 && pick >= 30 && pick < 80)
                pick = 0;
            if (pick < 30) begin
                len  = $urandom_range(1, 12);
                base = ($urandom_range(0, 7) == 0) ? FRAME_MAX - len + 1
                                                   : $urandom_range(0, FRAME_MAX - len);
                push_run(base, len);
            end else if (pick < 45) begin
                issue(fpsa_pkg::CMD_ALLOC, $urandom, $urandom_range(0, COUNT_MAX));
            end else if (pick < 65) begin
                cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_BURST)
                                                  : $urandom_range(1, (lvl < 24) ? 24 : lvl);
                issue(fpsa_pkg::CMD_CONTIG, $urandom,
                      (cnt > 12) ? $urandom_range(1, cnt) : cnt);
            end else if (pick < 80) begin
                cnt = (lvl < 1) ? 1 : lvl;
                if ($urandom_range(0, 7) == 0 || lvl > LEVEL_CAP)
                    cnt = $urandom_range(1, (cnt > MAX_BURST) ? MAX_BURST : cnt);
                else
                    cnt = $urandom_range(1, (cnt > 16) ? 16 : cnt);
                issue(fpsa_pkg::CMD_BULK, $urandom, cnt);
            end else if (pick < 90) begin
                issue(fpsa_pkg::CMD_FREE, $urandom, $urandom_range(0, COUNT_MAX));
            end else begin
                issue(fpsa_pkg::cmd_t'($urandom_range(0, 3)), $urandom,
                      $urandom_range(0, COUNT_MAX));
            end
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_checks();
        settle();

        random_traffic(140);
        // hold the result side off while requests keep coming
        hold_tickets++;
        random_traffic(110);
        // pause the request side until the block has caught up
        settle();
        random_traffic(130);

        // no idling from here on
        quiet = 1'b1;
        random_traffic(80);

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests and %0d results: all commands, empty and count errors,",
                 requests, results);
        $display("runs at both stack ends, a %0d-cycle hold-off and a pause for every result",
                 RX_HOLD_CYCLES);
        if (mismatches == 0 && owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
